>>> design/morus_pkg.sv
package morus_pkg;

  localparam int LaneW  = 64;
  localparam int Lanes  = 4;
  localparam int Words  = 5;

  // request kinds carried on tuser
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // per-round lane rotate amounts
  localparam int Rot0 = 13;
  localparam int Rot1 = 46;
  localparam int Rot2 = 38;
  localparam int Rot3 = 7;
  localparam int Rot4 = 4;

  localparam int InDataW  = 72;
  localparam int OutDataW = Lanes * LaneW;

  typedef logic [LaneW-1:0]            lane_t;
  typedef logic [Lanes-1:0][LaneW-1:0] word_t;
  typedef word_t [Words-1:0]           state_t;

  // rotate one lane left by n, 1 <= n <= 63
  function automatic lane_t rotl64(lane_t x, int n);
    return (x << n) | (x >> (LaneW - n));
  endfunction

  function automatic word_t lane_rotl(word_t w, int n);
    word_t r;
    for (int i = 0; i < Lanes; i++) begin
      r[i] = rotl64(w[i], n);
    end
    return r;
  endfunction

  // whole-word rotate left by k lanes
  function automatic word_t word_rotl(word_t w, int k);
    word_t r;
    for (int i = 0; i < Lanes; i++) begin
      r[i] = w[2'(i - k)];
    end
    return r;
  endfunction

  // a ^= b ^ (c & d), then per-lane rotate
  function automatic word_t mix(word_t a, word_t b, word_t c, word_t d, int n);
    return lane_rotl(a ^ b ^ (c & d), n);
  endfunction

endpackage

>>> design/morus_update.sv
module morus_update (
  input  morus_pkg::state_t s,
  output morus_pkg::word_t  stream,
  output morus_pkg::state_t s_next
);

  morus_pkg::word_t w0a, w0b, w1a, w1b, w2a, w2b, w3a, w3b, w4a, w4b;

  always_comb begin
    stream = s[0] ^ morus_pkg::word_rotl(s[1], 3) ^ (s[2] & s[3]);

    // five rounds, message fixed at zero
    w0a = morus_pkg::mix(s[0], s[3], s[1], s[2], morus_pkg::Rot0);
    w3a = morus_pkg::word_rotl(s[3], 1);
    w1a = morus_pkg::mix(s[1], s[4], s[2], w3a, morus_pkg::Rot1);
    w4a = morus_pkg::word_rotl(s[4], 2);
    w2a = morus_pkg::mix(s[2], w0a, w3a, w4a, morus_pkg::Rot2);
    w0b = morus_pkg::word_rotl(w0a, 3);
    w3b = morus_pkg::mix(w3a, w1a, w4a, w0b, morus_pkg::Rot3);
    w1b = morus_pkg::word_rotl(w1a, 2);
    w4b = morus_pkg::mix(w4a, w2a, w0b, w1b, morus_pkg::Rot4);
    w2b = morus_pkg::word_rotl(w2a, 1);

    s_next[0] = w0b;
    s_next[1] = w1b;
    s_next[2] = w2b;
    s_next[3] = w3b;
    s_next[4] = w4b;
  end

endmodule

>>> design/morus1280_zero_message_keystream.sv
// channel  dir  tdata (low bit up)                                    tuser
// s_axis   in   word_select[2:0] lane_select[4:3] lane_value[68:5]    req_type
//               bits 71:69 zero
// m_axis   out  stream_lane0..stream_lane3, 64 bits each, lane0 low   -
//
// one request per cycle sustained while steps do not wait: a request is held
// in the input register, then a load writes its lane or a step updates all
// five words through one pass of the round logic and lands in the output
// register. a step waits in the input register only while the output
// register is full and not being taken; loads never wait. rst is synchronous
// and clears the valid flags and the whole 1280-bit state to zero.
module morus1280_zero_message_keystream (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [morus_pkg::InDataW-1:0]    s_axis_tdata,  // word_select, lane_select, lane_value
  input  logic                             s_axis_tuser,  // req_type
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [morus_pkg::OutDataW-1:0]   m_axis_tdata   // stream_lane0 .. stream_lane3
);

  // input register
  logic                    in_valid;
  logic                    in_req;
  logic [2:0]              in_word;
  logic [1:0]              in_lane;
  morus_pkg::lane_t        in_value;

  // cipher state and output register
  morus_pkg::state_t       state;
  morus_pkg::state_t       state_next;
  morus_pkg::word_t        stream;
  morus_pkg::word_t        out_word;
  logic                    out_valid;

  logic                    out_free;
  logic                    advance;
  logic                    take_step;

  morus_update u_update (
    .s      (state),
    .stream (stream),
    .s_next (state_next)
  );

  // output slot is free when empty or being drained this cycle
  assign out_free  = !out_valid || m_axis_tready;
  // loads retire at once, steps need the output slot
  assign advance   = in_valid && ((in_req == morus_pkg::REQ_LOAD) || out_free);
  assign take_step = advance && (in_req == morus_pkg::REQ_STEP);

  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req   <= s_axis_tuser;
      in_word  <= s_axis_tdata[2:0];
      in_lane  <= s_axis_tdata[4:3];
      in_value <= s_axis_tdata[68:5];
    end
  end

  // state: lane write on a load with word_select below 5, full update on a step
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (take_step) begin
      state <= state_next;
    end else if (advance && (in_word < 3'(morus_pkg::Words))) begin
      state[in_word][in_lane] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_step) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_step) begin
      out_word <= stream;
    end
  end

endmodule
